>>> sv/ipv4_fragment_port_cache_defines.svh
// Assertion macros shared by the fragment port cache RTL.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef IPV4_FRAGMENT_PORT_CACHE_DEFINES_SVH
`define IPV4_FRAGMENT_PORT_CACHE_DEFINES_SVH

// same-cycle implication
`define IPFPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IPFPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ipfpc_pkg.sv
// Types and constants for the IPv4 fragment port cache.
// No dependencies; imported by ipfpc_cell and ipv4_fragment_port_cache.
`timescale 1ns / 1ps

package ipfpc_pkg;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [1:0] STATUS_OTHER = 2'd0;
    localparam logic [1:0] STATUS_OWN   = 2'd1;
    localparam logic [1:0] STATUS_HIT   = 2'd2;
    localparam logic [1:0] STATUS_MISS  = 2'd3;

    typedef struct packed {
        logic [15:0] ident;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
    } key_t;

    typedef struct packed {
        logic        valid;
        key_t        key;
        logic [15:0] sport;
        logic [15:0] dport;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_PULL
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SEL,
        S_UPD
    } state_t;

endpackage

>>> sv/ipfpc_cell.sv
// One position of the recency chain: holds one cache entry and compares it to the key.
// Depends on ipfpc_pkg.
`timescale 1ns / 1ps

module ipfpc_cell
    import ipfpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cell_op_t op,
    input  entry_t   left_entry,
    input  entry_t   right_entry,
    input  key_t     key,
    output entry_t   entry,
    output logic     match
);

    logic        valid_reg;
    logic        valid_next;
    key_t        key_reg;
    key_t        key_next;
    logic [15:0] sport_reg;
    logic [15:0] sport_next;
    logic [15:0] dport_reg;
    logic [15:0] dport_next;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;
        case (op)
            CELL_PUSH:
            begin
                valid_next = left_entry.valid;
                key_next   = left_entry.key;
                sport_next = left_entry.sport;
                dport_next = left_entry.dport;
            end
            CELL_PULL:
            begin
                valid_next = right_entry.valid;
                key_next   = right_entry.key;
                sport_next = right_entry.sport;
                dport_next = right_entry.dport;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        sport_reg <= sport_next;
        dport_reg <= dport_next;
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.sport = sport_reg;
    assign entry.dport = dport_reg;
    assign match       = valid_reg && (key_reg == key);

endmodule

>>> sv/ipv4_fragment_port_cache.sv
// Top level of the IPv4 fragment port cache: sequencer, chain of entry cells, result register.
// Depends on ipfpc_pkg, ipfpc_cell and ipv4_fragment_port_cache_defines.svh.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------------
//   in      | in_valid / in_ready  | protocol ident src_addr dst_addr frag_offset
//           |                      | more_frags pkt_src_port pkt_dst_port
//   out     | out_valid / out_ready| status flow_src_port flow_dst_port
//           |                      | entry_created entry_released
//
// Each header goes through transfer, compare in every cell, first-hit select, chain update.
// The chain shifts by one cell per item: right on insert, left from the hit on release.
// Reset empties every cell at once; no clearing pass.
// A stalled result holds the update cycle; the next header is taken once it issues.
`timescale 1ns / 1ps
`include "ipv4_fragment_port_cache_defines.svh"

module ipv4_fragment_port_cache
    import ipfpc_pkg::*;
#(
    parameter int ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  protocol,
    input  logic [15:0] ident,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [12:0] frag_offset,
    input  logic        more_frags,
    input  logic [15:0] pkt_src_port,
    input  logic [15:0] pkt_dst_port,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] flow_src_port,
    output logic [15:0] flow_dst_port,
    output logic        entry_created,
    output logic        entry_released
);

    localparam int LG = $clog2(ENTRIES);

    state_t state_reg;
    state_t state_next;

    key_t        key_reg;
    logic        off_nz_reg;
    logic        mf_reg;
    logic [15:0] sport_reg;
    logic [15:0] dport_reg;

    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] match_reg;
    logic [ENTRIES-1:0] pre [LG+1];
    logic [ENTRIES-1:0] ge_vec;
    logic [ENTRIES-1:0] first_hit;
    logic [ENTRIES-1:0] ge_reg;
    logic               hit_reg;
    logic [15:0]        hit_sport;
    logic [15:0]        hit_dport;
    logic [15:0]        hit_sport_reg;
    logic [15:0]        hit_dport_reg;

    entry_t             cell_entry [ENTRIES];
    cell_op_t           cell_op [ENTRIES];
    entry_t             new_entry;
    entry_t             empty_entry;
    logic [ENTRIES-1:0] valid_vec;

    logic is_l4;
    logic do_push;
    logic do_pull;
    logic upd_go;
    logic accept;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic [15:0] osport_reg;
    logic [15:0] osport_next;
    logic [15:0] odport_reg;
    logic [15:0] odport_next;
    logic        created_reg;
    logic        created_next;
    logic        released_reg;
    logic        released_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_CMP;
            S_CMP:  state_next = S_SEL;
            S_SEL:  state_next = S_UPD;
            S_UPD:  if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        upd_go   = 1'b0;
        case (state_reg)
            S_IDLE: in_ready = 1'b1;
            S_UPD:  upd_go   = !out_valid_reg || out_ready;
            default:
            begin
                in_ready = 1'b0;
                upd_go   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign accept = in_valid && in_ready;

    // hold the header for the whole item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg.ident <= ident;
            key_reg.src   <= src_addr;
            key_reg.dst   <= dst_addr;
            key_reg.proto <= protocol;
            off_nz_reg    <= (frag_offset != '0);
            mf_reg        <= more_frags;
            sport_reg     <= pkt_src_port;
            dport_reg     <= pkt_dst_port;
        end
    end

    assign new_entry.valid   = 1'b1;
    assign new_entry.key     = key_reg;
    assign new_entry.sport   = sport_reg;
    assign new_entry.dport   = dport_reg;
    assign empty_entry       = '0;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            entry_t left_in;
            entry_t right_in;
            if (gi == 0)
            begin : g_head
                assign left_in = new_entry;
            end
            else
            begin : g_mid_l
                assign left_in = cell_entry[gi-1];
            end
            if (gi == ENTRIES - 1)
            begin : g_tail
                assign right_in = empty_entry;
            end
            else
            begin : g_mid_r
                assign right_in = cell_entry[gi+1];
            end
            ipfpc_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (cell_op[gi]),
                .left_entry  (left_in),
                .right_entry (right_in),
                .key         (key_reg),
                .entry       (cell_entry[gi]),
                .match       (match_vec[gi])
            );
            assign valid_vec[gi] = cell_entry[gi].valid;
        end
    endgenerate

    // prefix OR of the match vector: every position at or after the first hit
    assign pre[0] = match_reg;
    generate
        for (gi = 0; gi < LG; gi++)
        begin : g_prefix
            assign pre[gi+1] = pre[gi] | (pre[gi] << (1 << gi));
        end
    endgenerate
    assign ge_vec    = pre[LG];
    assign first_hit = match_reg & ~(ge_vec << 1);

    always_comb
    begin
        hit_sport = '0;
        hit_dport = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_sport = hit_sport | ({16{first_hit[i]}} & cell_entry[i].sport);
            hit_dport = hit_dport | ({16{first_hit[i]}} & cell_entry[i].dport);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CMP)
        begin
            match_reg <= match_vec;
        end
        if (state_reg == S_SEL)
        begin
            ge_reg        <= ge_vec;
            hit_reg       <= |match_reg;
            hit_sport_reg <= hit_sport;
            hit_dport_reg <= hit_dport;
        end
    end

    assign is_l4   = (key_reg.proto == PROTO_TCP) || (key_reg.proto == PROTO_UDP);
    assign do_push = upd_go && is_l4 && !off_nz_reg && mf_reg;
    assign do_pull = upd_go && is_l4 && off_nz_reg && hit_reg && !mf_reg;

    // push inserts at the head; pull closes the gap left by the released entry
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (do_push)
            begin
                cell_op[i] = CELL_PUSH;
            end
            else if (do_pull && ge_reg[i])
            begin
                cell_op[i] = CELL_PULL;
            end
            else
            begin
                cell_op[i] = CELL_HOLD;
            end
        end
    end

    // result
    always_comb
    begin
        status_next    = status_reg;
        osport_next    = osport_reg;
        odport_next    = odport_reg;
        created_next   = created_reg;
        released_next  = released_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (upd_go)
        begin
            out_valid_next = 1'b1;
            status_next    = STATUS_OTHER;
            osport_next    = '0;
            odport_next    = '0;
            created_next   = 1'b0;
            released_next  = 1'b0;
            if (is_l4)
            begin
                if (!off_nz_reg)
                begin
                    status_next  = STATUS_OWN;
                    osport_next  = sport_reg;
                    odport_next  = dport_reg;
                    created_next = mf_reg;
                end
                else if (hit_reg)
                begin
                    status_next   = STATUS_HIT;
                    osport_next   = hit_sport_reg;
                    odport_next   = hit_dport_reg;
                    released_next = !mf_reg;
                end
                else
                begin
                    status_next = STATUS_MISS;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        osport_reg   <= osport_next;
        odport_reg   <= odport_next;
        created_reg  <= created_next;
        released_reg <= released_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign flow_src_port  = osport_reg;
    assign flow_dst_port  = odport_reg;
    assign entry_created  = created_reg;
    assign entry_released = released_reg;

    `IPFPC_ASSERT_NOW(a_valid_prefix, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0, "valid cells not a prefix of the chain")
    `IPFPC_ASSERT_NOW(a_single_hit, state_reg == S_SEL, $onehot0(first_hit), "more than one first hit")
    `IPFPC_ASSERT_NEXT(a_transfer_starts, accept, state_reg == S_CMP, "header transfer did not start compare")
    `IPFPC_ASSERT_NOW(a_release_on_hit, out_valid && entry_released, status == STATUS_HIT, "release without a fragment hit")

endmodule
